>>> sv/sbc_pkg.sv
// shared types, constants and helpers for the sphere/box collision pipeline
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

  localparam int FracBitsDef = 16;
  localparam int QuotBits    = 33;   // impulse quotient never exceeds t, which fits 33 bits

  typedef enum logic [2:0] {
    CfgCenterX = 3'd0,
    CfgCenterY = 3'd1,
    CfgCenterZ = 3'd2,
    CfgHalfX   = 3'd3,
    CfgHalfY   = 3'd4,
    CfgHalfZ   = 3'd5,
    CfgInvMass = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  localparam logic [16:0] ElastOne = 17'd65536;

  // result fields that ride along with the impulse math
  typedef struct packed {
    logic               hit;
    face_e              face;
    logic signed [31:0] fdist;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } pkt_t;

  // output of the face test stages
  typedef struct packed {
    pkt_t        pkt;
    logic [30:0] im1;
    logic [16:0] elast;
  } face_res_t;

  // carried through the divider
  typedef struct packed {
    pkt_t pkt;
    logic apply;
  } div_side_t;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/sphere_box_collision_impulse.sv
// top level: box registers, pipeline stages and the velocity update / output register
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------------------
// in       | sink      | in_valid_i / in_ready_o | sphere pos, radius, vel, inv mass, e
// out      | source    | out_valid_o/out_ready_i | hit, new velocity, face distance, face
// cfg      | sink      | cfg_valid_i/cfg_ready_o | register index, write data
//
// one beat accepted per cycle while the pipeline advances; a beat passes through 4
// face/impulse stages, 34 divider stages for the 33-bit quotient and the
// output register with the velocity update in front of it
// the whole pipeline moves together: it advances when the output register is
// empty or taken, so a stall freezes every stage and nothing is dropped
// reset clears valid bits and loads box center 0, half extents 1.0, box mass 0
`timescale 1ns / 1ps
`default_nettype none
module sphere_box_collision_impulse #(
  parameter int FRAC_BITS = sbc_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] sphere_x_i,
  input  wire logic signed [31:0] sphere_y_i,
  input  wire logic signed [31:0] sphere_z_i,
  input  wire logic        [30:0] sphere_radius_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] vel_z_i,
  input  wire logic        [30:0] sphere_inv_mass_i,
  input  wire logic        [16:0] elasticity_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    hit_o,
  output logic signed      [31:0] new_vel_x_o,
  output logic signed      [31:0] new_vel_y_o,
  output logic signed      [31:0] new_vel_z_o,
  output logic signed      [31:0] face_distance_o,
  output logic              [2:0] hit_face_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic         [2:0] cfg_index_i,
  input  wire logic        [31:0] cfg_data_i
);

  localparam logic [30:0] HalfOne = 31'(64'd1 << FRAC_BITS);

  // box registers
  logic signed [31:0] ctr_x_q, ctr_y_q, ctr_z_q;
  logic        [30:0] half_x_q, half_y_q, half_z_q, box_im_q;

  // global advance: whole pipe steps when the output slot frees up
  logic adv;
  assign adv         = !out_valid_o || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
      ctr_z_q  <= '0;
      half_x_q <= HalfOne;
      half_y_q <= HalfOne;
      half_z_q <= HalfOne;
      box_im_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sbc_pkg::CfgCenterX: ctr_x_q  <= cfg_data_i;
        sbc_pkg::CfgCenterY: ctr_y_q  <= cfg_data_i;
        sbc_pkg::CfgCenterZ: ctr_z_q  <= cfg_data_i;
        sbc_pkg::CfgHalfX:   half_x_q <= cfg_data_i[30:0];
        sbc_pkg::CfgHalfY:   half_y_q <= cfg_data_i[30:0];
        sbc_pkg::CfgHalfZ:   half_z_q <= cfg_data_i[30:0];
        sbc_pkg::CfgInvMass: box_im_q <= cfg_data_i[30:0];
        default: ;  // unused index, write ignored
      endcase
    end
  end

  // stages 1-2: distances and face pick
  logic               face_vld;
  sbc_pkg::face_res_t face_res;

  sbc_face u_face (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .valid_i           (in_valid_i),
    .sphere_x_i        (sphere_x_i),
    .sphere_y_i        (sphere_y_i),
    .sphere_z_i        (sphere_z_i),
    .sphere_radius_i   (sphere_radius_i),
    .vel_x_i           (vel_x_i),
    .vel_y_i           (vel_y_i),
    .vel_z_i           (vel_z_i),
    .sphere_inv_mass_i (sphere_inv_mass_i),
    .elasticity_i      (elasticity_i),
    .ctr_x_i           (ctr_x_q),
    .ctr_y_i           (ctr_y_q),
    .ctr_z_i           (ctr_z_q),
    .half_x_i          (half_x_q),
    .half_y_i          (half_y_q),
    .half_z_i          (half_z_q),
    .valid_o           (face_vld),
    .res_o             (face_res)
  );

  // stages 3-4: approach speed, restitution, numerator t * inv_m1
  logic               imp_vld;
  sbc_pkg::div_side_t imp_side;
  logic        [63:0] imp_num;
  logic        [32:0] imp_den;

  sbc_impulse #(
    .FRAC_BITS (FRAC_BITS)
  ) u_impulse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (face_vld),
    .res_i          (face_res),
    .box_inv_mass_i (box_im_q),
    .valid_o        (imp_vld),
    .side_o         (imp_side),
    .num_o          (imp_num),
    .den_o          (imp_den)
  );

  // divider: dv = floor(t * inv_m1 / (inv_m1 + inv_m2 + eps))
  logic               div_vld;
  sbc_pkg::div_side_t div_side;
  logic        [32:0] dv;

  sbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (imp_vld),
    .side_i  (imp_side),
    .num_i   (imp_num),
    .den_i   (imp_den),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quot_o  (dv)
  );

  // velocity update: add dv along the face normal, saturate to 32 bits
  logic signed [34:0] upd;
  logic signed [31:0] vsel, vnew;
  logic signed [31:0] nvx, nvy, nvz;

  always_comb begin
    case (div_side.pkt.face)
      sbc_pkg::FacePosX, sbc_pkg::FaceNegX: vsel = div_side.pkt.vx;
      sbc_pkg::FacePosY, sbc_pkg::FaceNegY: vsel = div_side.pkt.vy;
      default:                              vsel = div_side.pkt.vz;
    endcase
    // minus faces push the sphere toward negative axis
    upd  = div_side.pkt.face[0] ? ({{3{vsel[31]}}, vsel} - {2'b0, dv})
                                : ({{3{vsel[31]}}, vsel} + {2'b0, dv});
    vnew = div_side.apply ? sbc_pkg::sat35(upd) : vsel;
    nvx  = div_side.pkt.vx;
    nvy  = div_side.pkt.vy;
    nvz  = div_side.pkt.vz;
    case (div_side.pkt.face)
      sbc_pkg::FacePosX, sbc_pkg::FaceNegX: nvx = vnew;
      sbc_pkg::FacePosY, sbc_pkg::FaceNegY: nvy = vnew;
      default:                              nvz = vnew;
    endcase
  end

  // output register
  logic               out_valid_q;
  logic               hit_q;
  logic signed [31:0] nvx_q, nvy_q, nvz_q, dist_q;
  logic         [2:0] face_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= div_side.pkt.hit;
      nvx_q  <= nvx;
      nvy_q  <= nvy;
      nvz_q  <= nvz;
      dist_q <= div_side.pkt.fdist;
      face_q <= div_side.pkt.face;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign new_vel_x_o     = nvx_q;
  assign new_vel_y_o     = nvy_q;
  assign new_vel_z_o     = nvz_q;
  assign face_distance_o = dist_q;
  assign hit_face_o      = face_q;

  // a miss reports no face and no distance
  a_miss_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> face_distance_o == 32'sd0 && hit_face_o == 3'd0)
    else $error("miss with nonzero face fields");

  // face code stays in range
  a_face_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_face_o <= 3'd5)
    else $error("face code out of range");

  // a miss never changes the velocity past the divider
  a_miss_no_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld && !div_side.pkt.hit |-> !div_side.apply)
    else $error("impulse applied on a miss");

  // writes to an unused index leave the box alone
  a_cfg_unused : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == 3'd7 |=> $stable(box_im_q) && $stable(ctr_x_q)
      && $stable(half_x_q))
    else $error("unused config index modified a register");

endmodule
`default_nettype wire

>>> sv/sbc_face.sv
// face distances, overlap test and nearest-face select (two stages)
`timescale 1ns / 1ps
`default_nettype none
module sbc_face (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire logic signed [31:0] sphere_x_i,
  input  wire logic signed [31:0] sphere_y_i,
  input  wire logic signed [31:0] sphere_z_i,
  input  wire logic        [30:0] sphere_radius_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] vel_z_i,
  input  wire logic        [30:0] sphere_inv_mass_i,
  input  wire logic        [16:0] elasticity_i,
  input  wire logic signed [31:0] ctr_x_i,
  input  wire logic signed [31:0] ctr_y_i,
  input  wire logic signed [31:0] ctr_z_i,
  input  wire logic        [30:0] half_x_i,
  input  wire logic        [30:0] half_y_i,
  input  wire logic        [30:0] half_z_i,
  output logic                    valid_o,
  output sbc_pkg::face_res_t      res_o
);

  logic signed [34:0] d_d [6];
  logic signed [34:0] d_q [6];
  logic        [30:0] rad_q;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic        [30:0] im1_q;
  logic        [16:0] e_q;
  logic               v1_q;
  logic               v2_q;
  sbc_pkg::face_res_t res_d, res_q;

  function automatic logic signed [34:0] sx(input logic signed [31:0] a);
    return {{3{a[31]}}, a};
  endfunction

  always_comb begin
    d_d[0] = sx(sphere_x_i) - (sx(ctr_x_i) + {4'b0, half_x_i});
    d_d[1] = (sx(ctr_x_i) - {4'b0, half_x_i}) - sx(sphere_x_i);
    d_d[2] = sx(sphere_y_i) - (sx(ctr_y_i) + {4'b0, half_y_i});
    d_d[3] = (sx(ctr_y_i) - {4'b0, half_y_i}) - sx(sphere_y_i);
    d_d[4] = sx(sphere_z_i) - (sx(ctr_z_i) + {4'b0, half_z_i});
    d_d[5] = (sx(ctr_z_i) - {4'b0, half_z_i}) - sx(sphere_z_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q   <= d_d;
      rad_q <= sphere_radius_i;
      vx_q  <= vel_x_i;
      vy_q  <= vel_y_i;
      vz_q  <= vel_z_i;
      im1_q <= sphere_inv_mass_i;
      e_q   <= elasticity_i;
    end
  end

  // greatest distance wins, lower index on a tie
  always_comb begin
    logic               all_in;
    logic [2:0]         best;
    logic signed [34:0] bd;
    all_in = 1'b1;
    best   = 3'd0;
    bd     = d_q[0];
    for (int i = 0; i < 6; i++) begin
      if (!(d_q[i] < $signed({4'b0, rad_q}))) all_in = 1'b0;
      if (d_q[i] > bd) begin
        bd   = d_q[i];
        best = 3'(i);
      end
    end
    res_d.pkt.hit   = all_in;
    res_d.pkt.face  = all_in ? sbc_pkg::face_e'(best) : sbc_pkg::FacePosX;
    res_d.pkt.fdist = all_in ? sbc_pkg::sat35(bd) : 32'sd0;
    res_d.pkt.vx    = vx_q;
    res_d.pkt.vy    = vy_q;
    res_d.pkt.vz    = vz_q;
    res_d.im1       = im1_q;
    res_d.elast     = e_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

>>> sv/sbc_impulse.sv
// normal speed, restitution scaling and numerator product (two stages)
`timescale 1ns / 1ps
`default_nettype none
module sbc_impulse #(
  parameter int FRAC_BITS = sbc_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire sbc_pkg::face_res_t res_i,
  input  wire logic        [30:0] box_inv_mass_i,
  output logic                    valid_o,
  output sbc_pkg::div_side_t      side_o,
  output logic             [63:0] num_o,
  output logic             [32:0] den_o
);

  localparam longint EpsRaw = ((64'sd1 <<< FRAC_BITS) + 64'sd50000) / 64'sd100000;
  localparam logic [32:0] EpsLsb = (EpsRaw == 0) ? 33'd1 : 33'(EpsRaw);

  logic               neg;
  logic signed [31:0] vsel;
  logic signed [32:0] vn;
  logic        [31:0] mag;
  logic        [16:0] esat;
  logic        [49:0] prod;
  logic               v3_q, v4_q;
  sbc_pkg::div_side_t s3_q, s4_q;
  logic        [32:0] t_q;
  logic        [30:0] im1_q;
  logic        [32:0] den3_q, den4_q;
  logic        [63:0] num_q;

  always_comb begin
    neg = res_i.pkt.face[0];
    case (res_i.pkt.face)
      sbc_pkg::FacePosX, sbc_pkg::FaceNegX: vsel = res_i.pkt.vx;
      sbc_pkg::FacePosY, sbc_pkg::FaceNegY: vsel = res_i.pkt.vy;
      default:                              vsel = res_i.pkt.vz;
    endcase
    vn   = neg ? -{vsel[31], vsel} : {vsel[31], vsel};
    mag  = 32'(-vn);
    esat = (res_i.elast > sbc_pkg::ElastOne) ? sbc_pkg::ElastOne : res_i.elast;
    prod = 50'({1'b0, esat} + 18'(sbc_pkg::ElastOne)) * 50'(mag);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q.pkt   <= res_i.pkt;
      s3_q.apply <= res_i.pkt.hit && vn[32];
      t_q        <= prod[48:16];
      im1_q      <= res_i.im1;
      den3_q     <= {2'b0, res_i.im1} + {2'b0, box_inv_mass_i} + EpsLsb;
      s4_q       <= s3_q;
      num_q      <= 64'(t_q) * 64'(im1_q);
      den4_q     <= den3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign side_o  = s4_q;
  assign num_o   = num_q;
  assign den_o   = den4_q;

endmodule
`default_nettype wire

>>> sv/sbc_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module sbc_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire sbc_pkg::div_side_t side_i,
  input  wire logic        [63:0] num_i,
  input  wire logic        [32:0] den_i,
  output logic                    valid_o,
  output sbc_pkg::div_side_t      side_o,
  output logic             [32:0] quot_o
);

  localparam int Nq = sbc_pkg::QuotBits;

  logic                 vld_q  [Nq+1];
  sbc_pkg::div_side_t   side_q [Nq+1];
  logic          [63:0] num_q  [Nq+1];
  logic          [32:0] den_q  [Nq+1];
  logic          [32:0] rem_q  [Nq+1];
  logic          [32:0] quo_q  [Nq+1];

  // entry stage: top bits already below the divisor since quotient fits Nq bits
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      num_q[0]  <= num_i;
      den_q[0]  <= den_i;
      rem_q[0]  <= {2'b0, num_i[63:Nq]};
      quo_q[0]  <= '0;
    end
  end

  for (genvar i = 0; i < Nq; i++) begin : g_stage
    logic [33:0] trial;
    logic        ge;
    assign trial = {rem_q[i], num_q[i][Nq-1-i]};
    assign ge    = trial >= {1'b0, den_q[i]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        side_q[i+1] <= side_q[i];
        num_q[i+1]  <= num_q[i];
        den_q[i+1]  <= den_q[i];
        rem_q[i+1]  <= ge ? 33'(trial - {1'b0, den_q[i]}) : trial[32:0];
        quo_q[i+1]  <= {quo_q[i][31:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Nq; i++) vld_q[i] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int i = 0; i < Nq; i++) vld_q[i+1] <= vld_q[i];
    end
  end

  assign valid_o = vld_q[Nq];
  assign side_o  = side_q[Nq];
  assign quot_o  = quo_q[Nq];

endmodule
`default_nettype wire
